[hw/rtl/gaussian_splat_alpha_eval_top_macros.svh]
// Assertion macros shared by the checker of the splat alpha evaluator.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GAUSSIAN_SPLAT_ALPHA_EVAL_TOP_MACROS_SVH
`define GAUSSIAN_SPLAT_ALPHA_EVAL_TOP_MACROS_SVH

// Assertion that is switched off while reset is high.
`define GSA_ASSERT_RUN(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked during reset as well.
`define GSA_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/gsa_pkg.sv]
// Types, constants and the exponential table function of the splat alpha evaluator.
// Depends on nothing; imported by every module of the block.
package gsa_pkg;

   localparam int REQ_W = 256;
   localparam int RSP_W = 24;
   localparam int QBITS = 17;
   localparam int NEXP = 10;
   localparam logic [30:0] EXP_M1 = 31'd1580030169;
   localparam logic [31:0] EPS_RESET = 32'd4295;
   localparam logic [16:0] ALPHA_MAX = 17'd65536;

   typedef struct packed {
      logic en;
      logic vld;
   } gsa_pipe_type;

   typedef struct packed {
      logic [16:0] opac;
      logic deg;
      logic in_radius;
   } gsa_side_type;

   typedef struct packed {
      logic pos;
      logic sat;
   } gsa_qctl_type;

   // Restoring division, used only while the table constants are elaborated.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-j / 2^b) in Q1.32 from a truncated Taylor series.
   function automatic logic [32:0] exp_frac(input int unsigned j, input int unsigned b);
      longint unsigned u;
      longint unsigned term;
      longint sum;
      u = longint'(j) << (32 - b);
      term = 64'd1 << 32;
      sum = 64'sd1 <<< 32;
      for (int k = 1; k <= 13; k++) begin
         term = div_u64((term * u) >> 32, longint'(k));
         if (k[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return sum[32:0];
   endfunction

endpackage

[hw/rtl/gsa_div.sv]
// Pipelined restoring divider that forms the scaled exponent, one quotient bit per stage.
// Depends on gsa_pkg.
module gsa_div #(
   parameter int DW = 89
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gsa_pkg::gsa_pipe_type      pipe_in,
   input  logic [DW-1:0]              r_in,
   input  logic [63:0]                d_in,
   input  gsa_pkg::gsa_qctl_type      qctl_in,
   input  gsa_pkg::gsa_side_type      side_in,
   output logic                       vld_out,
   output logic [gsa_pkg::QBITS-1:0]  x_out,
   output gsa_pkg::gsa_qctl_type      qctl_out,
   output gsa_pkg::gsa_side_type      side_out
);
   import gsa_pkg::*;

   logic [QBITS-1:0] vld_ff;
   logic [DW-1:0]    r_ff [QBITS];
   logic [63:0]      d_ff [QBITS];
   logic [QBITS-1:0] x_ff [QBITS];
   gsa_qctl_type     qctl_ff [QBITS];
   gsa_side_type     side_ff [QBITS];

   for (genvar k = 0; k < QBITS; k++) begin : g_stage
      logic             vld_src;
      logic [DW-1:0]    r_src;
      logic [63:0]      d_src;
      logic [QBITS-1:0] x_src;
      gsa_qctl_type     qctl_src;
      gsa_side_type     side_src;
      logic [DW-1:0]    t;
      logic             ge;

      if (k == 0) begin : g_first
         assign vld_src = pipe_in.vld;
         assign r_src = r_in;
         assign d_src = d_in;
         assign x_src = '0;
         assign qctl_src = qctl_in;
         assign side_src = side_in;
      end else begin : g_next
         assign vld_src = vld_ff[k-1];
         assign r_src = r_ff[k-1];
         assign d_src = d_ff[k-1];
         assign x_src = x_ff[k-1];
         assign qctl_src = qctl_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      assign t = DW'(d_src) << (QBITS - 1 - k);
      assign ge = (r_src >= t);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (pipe_in.en) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_in.en) begin
            r_ff[k] <= ge ? (r_src - t) : r_src;
            d_ff[k] <= d_src;
            x_ff[k] <= x_src | (QBITS'(ge) << (QBITS - 1 - k));
            qctl_ff[k] <= qctl_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign vld_out = vld_ff[QBITS-1];
   assign x_out = x_ff[QBITS-1];
   assign qctl_out = qctl_ff[QBITS-1];
   assign side_out = side_ff[QBITS-1];

endmodule

[hw/rtl/gsa_exp.sv]
// Exponential pipeline: fraction table lookup, then one exp(-1) factor per stage.
// Depends on gsa_pkg.
module gsa_exp #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  gsa_pkg::gsa_pipe_type      pipe_in,
   input  logic [gsa_pkg::QBITS-1:0]  x_in,
   input  gsa_pkg::gsa_side_type      side_in,
   output logic                       vld_out,
   output logic [32:0]                w_out,
   output gsa_pkg::gsa_side_type      side_out
);
   import gsa_pkg::*;

   localparam int TAB_N = 1 << EXP_TABLE_BITS;

   logic [32:0]  rom [TAB_N];
   logic         vld0_ff;
   logic [32:0]  w0_ff;
   logic [3:0]   n0_ff;
   gsa_side_type side0_ff;

   logic [NEXP-1:0] vld_ff;
   logic [32:0]     w_ff [NEXP];
   logic [3:0]      n_ff [NEXP];
   gsa_side_type    side_ff [NEXP];

   for (genvar j = 0; j < TAB_N; j++) begin : g_rom
      localparam logic [32:0] ENTRY = exp_frac(j, EXP_TABLE_BITS);
      assign rom[j] = ENTRY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
      end else if (pipe_in.en) begin
         vld0_ff <= pipe_in.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_in.en) begin
         w0_ff <= rom[x_in[EXP_TABLE_BITS-1:0]];
         n0_ff <= x_in[EXP_TABLE_BITS+3:EXP_TABLE_BITS];
         side0_ff <= side_in;
      end
   end

   for (genvar i = 0; i < NEXP; i++) begin : g_stage
      logic         vld_src;
      logic [32:0]  w_src;
      logic [3:0]   n_src;
      gsa_side_type side_src;
      logic [63:0]  prod;

      if (i == 0) begin : g_first
         assign vld_src = vld0_ff;
         assign w_src = w0_ff;
         assign n_src = n0_ff;
         assign side_src = side0_ff;
      end else begin : g_next
         assign vld_src = vld_ff[i-1];
         assign w_src = w_ff[i-1];
         assign n_src = n_ff[i-1];
         assign side_src = side_ff[i-1];
      end

      assign prod = 64'(w_src) * 64'(EXP_M1) + 64'h8000_0000;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (pipe_in.en) begin
            vld_ff[i] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (pipe_in.en) begin
            w_ff[i] <= (n_src > 4'(i)) ? {1'b0, prod[63:32]} : w_src;
            n_ff[i] <= n_src;
            side_ff[i] <= side_src;
         end
      end
   end

   assign vld_out = vld_ff[NEXP-1];
   assign w_out = w_ff[NEXP-1];
   assign side_out = side_ff[NEXP-1];

endmodule

[hw/rtl/gaussian_splat_alpha_eval_top.sv]
// Path: stages A to G, gsa_div, gsa_exp, product register, response register.
// Throughput: one word per cycle; every stage moves together, and the request side
// stalls only while a second response word waits behind a stalled one.
// Reset clears every valid bit and sets det_epsilon to 4295.
// Top level of the splat alpha evaluator; uses gsa_pkg, gsa_div and gsa_exp.
module gaussian_splat_alpha_eval_top #(
   parameter int EXP_TABLE_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // pixel_x, pixel_y, center_x, center_y, cov_xx, cov_xy, cov_yx, cov_yy, opacity,
   // radius, zero fill
   input  logic [gsa_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // alpha_out, inside_res, degenerate, zero fill
   output logic [gsa_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       csr_we,
   input  logic [31:0]                csr_wdata
);
   import gsa_pkg::*;

   localparam int DW = 81 + EXP_TABLE_BITS;
   localparam logic [QBITS-1:0] XMAX = QBITS'(10 << EXP_TABLE_BITS);

   logic        en;
   logic        rsp_free;
   logic [31:0] eps_ff;
   logic [6:0]  vld_ff;

   // Stage A
   logic signed [21:0] dx_ff, dy_ff;
   logic signed [31:0] cxx_a_ff, cxy_a_ff, cyx_a_ff, cyy_a_ff;
   logic [16:0]        opac_a_ff;
   logic [19:0]        rad_a_ff;
   // Stage B
   logic signed [63:0] p_ff, q_ff;
   logic signed [33:0] s_ff;
   logic [41:0]        dx2_ff, dy2_ff;
   logic signed [42:0] dxy_ff;
   logic [39:0]        rr_ff;
   logic signed [31:0] cxx_b_ff, cyy_b_ff;
   logic [16:0]        opac_b_ff;
   // Stage C
   logic signed [64:0] det;
   logic signed [43:0] dx2w, dy2w;
   logic signed [53:0] pa_lo, pa_hi, pc_lo, pc_hi;
   logic signed [56:0] pb_lo;
   logic signed [54:0] pb_hi;
   logic               det_neg_c_ff, inside_c_ff;
   logic [63:0]        dm_c_ff;
   logic signed [53:0] pa_lo_ff, pa_hi_ff, pc_lo_ff, pc_hi_ff;
   logic signed [56:0] pb_lo_ff;
   logic signed [54:0] pb_hi_ff;
   logic [16:0]        opac_c_ff;
   // Stage D
   logic signed [79:0] t1_ff, t2_ff, t3_ff;
   logic               det_neg_d_ff;
   logic [63:0]        dm_d_ff;
   gsa_side_type       side_d_ff;
   // Stage E
   logic signed [79:0] n_ff;
   logic               det_neg_e_ff;
   logic [63:0]        dm_e_ff;
   gsa_side_type       side_e_ff;
   // Stage F
   logic [79:0]        nmag_ff, dm20_ff;
   logic               same_sign_ff;
   logic [63:0]        dm_f_ff;
   gsa_side_type       side_f_ff;
   // Stage G
   logic [DW-1:0]      r0_ff;
   logic [63:0]        dm_g_ff;
   gsa_qctl_type       qctl_g_ff;
   gsa_side_type       side_g_ff;
   // Divider, exponential and output
   logic               div_vld;
   logic [QBITS-1:0]   div_x, x_fix;
   gsa_qctl_type       div_qctl;
   gsa_side_type       div_side;
   logic               exp_vld;
   logic [32:0]        exp_w;
   gsa_side_type       exp_side;
   logic               m_vld_ff;
   logic [49:0]        m_prod_ff;
   gsa_side_type       m_side_ff;
   logic [49:0]        m_round;
   logic [16:0]        alpha_nx;
   logic               skid_vld_ff;
   logic [16:0]        skid_alpha_ff;
   logic               skid_inside_ff, skid_deg_ff;
   logic               rsp_vld_ff;
   logic [16:0]        rsp_alpha_ff;
   logic               rsp_inside_ff, rsp_deg_ff;

   assign en = !skid_vld_ff;
   assign req_tready = en;
   assign rsp_free = !rsp_vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_RESET;
      end else if (csr_we) begin
         eps_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         m_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[5:0], req_tvalid};
            m_vld_ff <= exp_vld;
         end
         if (rsp_free) begin
            rsp_vld_ff <= skid_vld_ff || m_vld_ff;
         end
         skid_vld_ff <= (skid_vld_ff || m_vld_ff) && !rsp_free;
      end
   end

   always_comb begin
      det = 65'(p_ff) - 65'(q_ff);
      dx2w = 44'(dx_ff) * 44'(dx_ff);
      dy2w = 44'(dy_ff) * 44'(dy_ff);
      pa_lo = cyy_b_ff * $signed({1'b0, dx2_ff[20:0]});
      pa_hi = cyy_b_ff * $signed({1'b0, dx2_ff[41:21]});
      pb_lo = s_ff * $signed({1'b0, dxy_ff[21:0]});
      pb_hi = s_ff * $signed(dxy_ff[42:22]);
      pc_lo = cxx_b_ff * $signed({1'b0, dy2_ff[20:0]});
      pc_hi = cxx_b_ff * $signed({1'b0, dy2_ff[41:21]});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= $signed({req_tdata[20], req_tdata[20:0]})
                - $signed({req_tdata[62], req_tdata[62:42]});
         dy_ff <= $signed({req_tdata[41], req_tdata[41:21]})
                - $signed({req_tdata[83], req_tdata[83:63]});
         cxx_a_ff <= $signed(req_tdata[115:84]);
         cxy_a_ff <= $signed(req_tdata[147:116]);
         cyx_a_ff <= $signed(req_tdata[179:148]);
         cyy_a_ff <= $signed(req_tdata[211:180]);
         opac_a_ff <= req_tdata[228:212];
         rad_a_ff <= req_tdata[248:229];

         p_ff <= 64'(cxx_a_ff) * 64'(cyy_a_ff);
         q_ff <= 64'(cxy_a_ff) * 64'(cyx_a_ff);
         s_ff <= -(34'(cxy_a_ff) + 34'(cyx_a_ff));
         dx2_ff <= dx2w[41:0];
         dy2_ff <= dy2w[41:0];
         dxy_ff <= 43'(dx_ff) * 43'(dy_ff);
         rr_ff <= 40'(rad_a_ff) * 40'(rad_a_ff);
         cxx_b_ff <= cxx_a_ff;
         cyy_b_ff <= cyy_a_ff;
         opac_b_ff <= opac_a_ff;

         det_neg_c_ff <= det[64];
         dm_c_ff <= det[64] ? 64'(-det) : det[63:0];
         inside_c_ff <= (43'(dx2_ff) + 43'(dy2_ff)) <= 43'(rr_ff);
         pa_lo_ff <= pa_lo;
         pa_hi_ff <= pa_hi;
         pb_lo_ff <= pb_lo;
         pb_hi_ff <= pb_hi;
         pc_lo_ff <= pc_lo;
         pc_hi_ff <= pc_hi;
         opac_c_ff <= opac_b_ff;

         t1_ff <= (80'(pa_hi_ff) <<< 21) + 80'(pa_lo_ff);
         t2_ff <= (80'(pb_hi_ff) <<< 22) + 80'(pb_lo_ff);
         t3_ff <= (80'(pc_hi_ff) <<< 21) + 80'(pc_lo_ff);
         det_neg_d_ff <= det_neg_c_ff;
         dm_d_ff <= dm_c_ff;
         side_d_ff.opac <= opac_c_ff;
         side_d_ff.deg <= (dm_c_ff == 64'd0) || (dm_c_ff < 64'(eps_ff));
         side_d_ff.in_radius <= inside_c_ff;

         n_ff <= t1_ff + t2_ff + t3_ff;
         det_neg_e_ff <= det_neg_d_ff;
         dm_e_ff <= dm_d_ff;
         side_e_ff <= side_d_ff;

         nmag_ff <= n_ff[79] ? 80'(-n_ff) : 80'(n_ff);
         dm20_ff <= (80'(dm_e_ff) << 4) + (80'(dm_e_ff) << 2);
         same_sign_ff <= (n_ff[79] == det_neg_e_ff);
         dm_f_ff <= dm_e_ff;
         side_f_ff <= side_e_ff;

         r0_ff <= DW'(nmag_ff) << (EXP_TABLE_BITS - 1);
         dm_g_ff <= dm_f_ff;
         qctl_g_ff.pos <= (nmag_ff != 80'd0) && same_sign_ff;
         qctl_g_ff.sat <= (nmag_ff >= dm20_ff);
         side_g_ff <= side_f_ff;
      end
   end

   gsa_div #(
      .DW(DW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .pipe_in ('{en: en, vld: vld_ff[6]}),
      .r_in    (r0_ff),
      .d_in    (dm_g_ff),
      .qctl_in (qctl_g_ff),
      .side_in (side_g_ff),
      .vld_out (div_vld),
      .x_out   (div_x),
      .qctl_out(div_qctl),
      .side_out(div_side)
   );

   always_comb begin
      if (!div_qctl.pos) begin
         x_fix = '0;
      end else if (div_qctl.sat || (div_x > XMAX)) begin
         x_fix = XMAX;
      end else begin
         x_fix = div_x;
      end
   end

   gsa_exp #(
      .EXP_TABLE_BITS(EXP_TABLE_BITS)
   ) u_exp (
      .clock   (clock),
      .reset   (reset),
      .pipe_in ('{en: en, vld: div_vld}),
      .x_in    (x_fix),
      .side_in (div_side),
      .vld_out (exp_vld),
      .w_out   (exp_w),
      .side_out(exp_side)
   );

   assign m_round = m_prod_ff + 50'h8000_0000;

   always_comb begin
      if (m_side_ff.deg) begin
         alpha_nx = '0;
      end else if (m_round[49:32] > 18'(ALPHA_MAX)) begin
         alpha_nx = ALPHA_MAX;
      end else begin
         alpha_nx = m_round[48:32];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_prod_ff <= 50'(exp_side.opac) * 50'(exp_w);
         m_side_ff <= exp_side;
         if (!rsp_free) begin
            skid_alpha_ff <= alpha_nx;
            skid_inside_ff <= m_side_ff.in_radius;
            skid_deg_ff <= m_side_ff.deg;
         end
      end
      if (rsp_free) begin
         if (skid_vld_ff) begin
            rsp_alpha_ff <= skid_alpha_ff;
            rsp_inside_ff <= skid_inside_ff;
            rsp_deg_ff <= skid_deg_ff;
         end else begin
            rsp_alpha_ff <= alpha_nx;
            rsp_inside_ff <= m_side_ff.in_radius;
            rsp_deg_ff <= m_side_ff.deg;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = {5'd0, rsp_deg_ff, rsp_inside_ff, rsp_alpha_ff};

endmodule

[hw/rtl/gsa_checker.sv]
// Port-level checker of the splat alpha evaluator, bound to its top level.
// Depends on gsa_pkg and gaussian_splat_alpha_eval_top_macros.svh.
`include "gaussian_splat_alpha_eval_top_macros.svh"

module gsa_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [gsa_pkg::RSP_W-1:0]  rsp_tdata
);
   import gsa_pkg::*;

   `GSA_ASSERT_RUN(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")
   `GSA_ASSERT_ALL(a_reset_empty, clock, reset |=> !rsp_tvalid, "response valid right after reset")
   `GSA_ASSERT_RUN(a_ready_free, clock, reset, !rsp_tvalid |-> req_tready, "request stalled with an empty output")
   `GSA_ASSERT_RUN(a_deg_zero, clock, reset, rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[16:0] == 17'd0, "degenerate word with nonzero alpha")

endmodule

bind gaussian_splat_alpha_eval_top gsa_checker u_gsa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
